>>> hw/rtl/sbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbf_pkg
// Shared types and constants for the store buffer with forwarding.
// ----------------------------------------------------------------------------
package sbf_pkg;

  localparam int SBF_DEPTH = 16;
  localparam int SBF_AW    = 32;
  localparam int SBF_DW    = 32;
  localparam logic [SBF_AW-1:0] SBF_WORD_MASK = 32'hFFFF_FFFC;

  typedef enum logic [1:0] {
    FN_PUSH  = 2'd0,
    FN_POP   = 2'd1,
    FN_FLUSH = 2'd2,
    FN_QUERY = 2'd3
  } sbf_func_t;

  typedef struct packed {
    logic              valid;
    logic [SBF_AW-1:0] addr;
    logic [SBF_DW-1:0] data;
  } sbf_entry_t;

  // row-wide control, same for every cell
  typedef struct packed {
    logic clear;
    logic shift;
    logic rotate;
  } sbf_ctl_t;

endpackage

>>> hw/rtl/store_buffer_with_forwarding.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// store_buffer_with_forwarding
// Store queue with store-to-load forwarding, built as a row of slot cells.
// ----------------------------------------------------------------------------
//  channel  handshake             fields
//  req      req_valid/req_stall   func, addr, store_value
//  rsp      rsp_valid/rsp_stall   status, hit, out_addr, out_data
//
//  Push, pop and flush are done at the accept edge, where the result is registered.
//  Query rotates the cell row once, comparing at the top cell; the result
//  is registered after the last compare, and no item is taken meanwhile.
//  Oldest store sits in cell 0; a pop shifts the row down by one cell.
//  One item in flight; a new item is taken once the result register frees.
//  Synchronous reset clears all valid marks and the fill count.
// ----------------------------------------------------------------------------
module store_buffer_with_forwarding #(
  parameter int DEPTH = sbf_pkg::SBF_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [1:0]                  func,
  input  logic [sbf_pkg::SBF_AW-1:0]  addr,
  input  logic [sbf_pkg::SBF_DW-1:0]  store_value,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic                        status,
  output logic                        hit,
  output logic [sbf_pkg::SBF_AW-1:0]  out_addr,
  output logic [sbf_pkg::SBF_DW-1:0]  out_data
);
  import sbf_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t            state;
  logic [CW-1:0]     count;
  logic [IW-1:0]     scan_idx;
  logic [SBF_AW-1:0] key;
  logic              hit_acc;
  logic [SBF_DW-1:0] fwd_acc;

  sbf_entry_t        ent [DEPTH];
  sbf_ctl_t          ctl;
  logic              accept;
  logic              push_ok;
  logic              pop_ok;
  logic              scan_match;
  logic              scan_last;
  logic              rsp_set;
  logic              hit_next;
  logic [SBF_DW-1:0] fwd_next;
  sbf_entry_t        empty_ent;

  assign empty_ent = '{valid: 1'b0, addr: '0, data: '0};

  assign req_stall = (state != ST_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;
  assign push_ok   = accept && (sbf_func_t'(func) == FN_PUSH) && (count != CW'(DEPTH));
  assign pop_ok    = accept && (sbf_func_t'(func) == FN_POP) && (count != '0);

  always_comb begin
    ctl.clear  = accept && (sbf_func_t'(func) == FN_FLUSH);
    ctl.shift  = pop_ok;
    ctl.rotate = (state == ST_SCAN);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sbf_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .wr      (push_ok && (count == CW'(i))),
      .wr_addr (addr),
      .wr_data (store_value),
      .upper   ((i == DEPTH - 1) ? empty_ent : ent[(i + 1) % DEPTH]),
      .lower   ((i == 0) ? ent[DEPTH - 1] : ent[(i + DEPTH - 1) % DEPTH]),
      .ent     (ent[i])
    );
  end

  assign scan_match = ent[DEPTH-1].valid &&
                      ((ent[DEPTH-1].addr & SBF_WORD_MASK) == key);
  assign scan_last  = (scan_idx == IW'(DEPTH - 1));
  assign hit_next   = hit_acc || scan_match;
  assign fwd_next   = hit_acc ? fwd_acc : ent[DEPTH-1].data;
  assign rsp_set    = (accept && (sbf_func_t'(func) != FN_QUERY)) ||
                      ((state == ST_SCAN) && scan_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      scan_idx  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_set) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (sbf_func_t'(func))
              FN_PUSH: begin
                if (push_ok) begin
                  count <= count + CW'(1);
                end
              end
              FN_POP: begin
                if (pop_ok) begin
                  count <= count - CW'(1);
                end
              end
              FN_FLUSH: begin
                count <= '0;
              end
              FN_QUERY: begin
                state    <= ST_SCAN;
                scan_idx <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_last) begin
            state <= ST_IDLE;
          end else begin
            scan_idx <= scan_idx + IW'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      key      <= addr & SBF_WORD_MASK;
      hit_acc  <= 1'b0;
      fwd_acc  <= '0;
      hit      <= 1'b0;
      status   <= ((sbf_func_t'(func) == FN_PUSH) && !push_ok) ||
                  ((sbf_func_t'(func) == FN_POP) && !pop_ok);
      out_addr <= pop_ok ? ent[0].addr : '0;
      out_data <= pop_ok ? ent[0].data : '0;
    end else if (state == ST_SCAN) begin
      hit_acc <= hit_next;
      fwd_acc <= fwd_next;
      if (scan_last) begin
        status   <= 1'b0;
        hit      <= hit_next;
        out_addr <= '0;
        out_data <= hit_next ? fwd_next : '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_scan_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> req_stall)
    else $error("item accepted during search");

  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (ent[0].valid == (count != '0)))
    else $error("head cell valid disagrees with fill count");

  a_scan_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && scan_last) |=> (state == ST_IDLE && rsp_valid))
    else $error("search did not deliver a result");
`endif

endmodule

>>> hw/rtl/sbf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbf_cell
// One store slot: loads a new store, takes its upper neighbor on a pop,
// or its lower neighbor while the row rotates for a search; a flush clears it.
// ----------------------------------------------------------------------------
module sbf_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  sbf_pkg::sbf_ctl_t             ctl,
  input  logic                          wr,
  input  logic [sbf_pkg::SBF_AW-1:0]    wr_addr,
  input  logic [sbf_pkg::SBF_DW-1:0]    wr_data,
  input  sbf_pkg::sbf_entry_t           upper,
  input  sbf_pkg::sbf_entry_t           lower,
  output sbf_pkg::sbf_entry_t           ent
);
  import sbf_pkg::*;

  logic              valid;
  logic [SBF_AW-1:0] addr;
  logic [SBF_DW-1:0] data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end else if (wr) begin
      valid <= 1'b1;
    end else if (ctl.shift) begin
      valid <= upper.valid;
    end else if (ctl.rotate) begin
      valid <= lower.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      addr <= wr_addr;
      data <= wr_data;
    end else if (ctl.shift) begin
      addr <= upper.addr;
      data <= upper.data;
    end else if (ctl.rotate) begin
      addr <= lower.addr;
      data <= lower.data;
    end
  end

  assign ent = '{valid: valid, addr: addr, data: data};

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the store buffer with forwarding. A directed table
// walks the empty, full, wrap, flush and youngest-match cases; random traffic
// in fill, drain and balanced phases follows. Each accepted item runs through
// an in-bench model of the buffer, and every response item is compared field
// by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import sbf_pkg::*;

  localparam int N_RANDOM     = 1425;
  localparam int IDLE_PCT     = 32;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = SBF_DEPTH + 8;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct {
    logic              status;
    logic              hit;
    logic [SBF_AW-1:0] oaddr;
    logic [SBF_DW-1:0] odata;
  } sb_result_t;

  typedef struct {
    sbf_func_t         fn;
    logic [SBF_AW-1:0] addr;
    logic [SBF_DW-1:0] value;
    int                count;
    bit                has_exp;
    sb_result_t        exp;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  logic [1:0]        func = FN_PUSH;
  logic [SBF_AW-1:0] addr = '0;
  logic [SBF_DW-1:0] store_value = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  logic              status;
  logic              hit;
  logic [SBF_AW-1:0] out_addr;
  logic [SBF_DW-1:0] out_data;

  // buffer model
  logic [SBF_AW-1:0] sb_addr [SBF_DEPTH];
  logic [SBF_DW-1:0] sb_data [SBF_DEPTH];
  logic              sb_valid [SBF_DEPTH];
  int                sb_head;
  int                sb_tail;

  sb_result_t        expected_results [$];
  dir_row_t          dir_rows [$];
  logic [SBF_AW-1:0] addr_pool [8];
  int                errors = 0;
  int                cycle_count = 0;
  bit                steady = 1'b0;
  bit                hold_request = 1'b0;

  store_buffer_with_forwarding #(.DEPTH(SBF_DEPTH)) dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .func        (func),
    .addr        (addr),
    .store_value (store_value),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .hit         (hit),
    .out_addr    (out_addr),
    .out_data    (out_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("FAIL store_buffer_with_forwarding");
    $finish;
  end

  function automatic sb_result_t mk_res(logic st, logic h, logic [SBF_AW-1:0] oa,
                                        logic [SBF_DW-1:0] od);
    sb_result_t r;
    r.status = st;
    r.hit    = h;
    r.oaddr  = oa;
    r.odata  = od;
    return r;
  endfunction

  function automatic sb_result_t buffer_step(sbf_func_t fn, logic [SBF_AW-1:0] a,
                                            logic [SBF_DW-1:0] v);
    sb_result_t r;
    int         i;
    int         idx;
    bit         found;
    r = mk_res(1'b0, 1'b0, '0, '0);
    found = 1'b0;
    case (fn)
      FN_PUSH: begin
        if (sb_valid[sb_tail]) begin
          r.status = 1'b1;
        end else begin
          sb_addr[sb_tail]  = a;
          sb_data[sb_tail]  = v;
          sb_valid[sb_tail] = 1'b1;
          sb_tail = (sb_tail + 1) % SBF_DEPTH;
        end
      end
      FN_POP: begin
        if (!sb_valid[sb_head]) begin
          r.status = 1'b1;
        end else begin
          r.oaddr = sb_addr[sb_head];
          r.odata = sb_data[sb_head];
          sb_valid[sb_head] = 1'b0;
          sb_head = (sb_head + 1) % SBF_DEPTH;
        end
      end
      FN_FLUSH: begin
        for (i = 0; i < SBF_DEPTH; i++) sb_valid[i] = 1'b0;
        sb_head = 0;
        sb_tail = 0;
      end
      default: begin
        // youngest first
        for (i = 0; i < SBF_DEPTH && !found; i++) begin
          idx = (sb_tail + SBF_DEPTH - 1 - i) % SBF_DEPTH;
          if (sb_valid[idx] && ((sb_addr[idx] & SBF_WORD_MASK) == (a & SBF_WORD_MASK))) begin
            r.hit   = 1'b1;
            r.odata = sb_data[idx];
            found   = 1'b1;
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    errors++;
  endtask

  task automatic add_row(sbf_func_t fn, logic [SBF_AW-1:0] a, logic [SBF_DW-1:0] v,
                         int cnt, bit has_exp, sb_result_t exp);
    dir_row_t row;
    row.fn      = fn;
    row.addr    = a;
    row.value   = v;
    row.count   = cnt;
    row.has_exp = has_exp;
    row.exp     = exp;
    dir_rows.push_back(row);
  endtask

  task automatic offer_item(sbf_func_t fn, logic [SBF_AW-1:0] a, logic [SBF_DW-1:0] v,
                            bit has_exp, sb_result_t typed);
    sb_result_t pred;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid   <= 1'b1;
    func        <= fn;
    addr        <= a;
    store_value <= v;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pred = buffer_step(fn, a, v);
    expected_results.push_back(has_exp ? typed : pred);
  endtask

  function automatic logic [SBF_AW-1:0] pick_addr();
    if ($urandom_range(0, 99) < 70)
      return (addr_pool[$urandom_range(0, 7)] & SBF_WORD_MASK) | ($urandom() & 32'h3);
    return $urandom();
  endfunction

  function automatic logic [SBF_DW-1:0] pick_value();
    int w;
    w = $urandom_range(0, 99);
    if (w < 5) return '0;
    if (w < 10) return '1;
    return $urandom();
  endfunction

  // response side: stall pattern and one long hold-off
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        hold--;
      end else if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : rsp_check
    sb_result_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_results.size() == 0) begin
        $display("unexpected response item at cycle %0d", cycle_count);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status)
          report_mismatch("status", 32'(status), 32'(want.status));
        if (hit !== want.hit)
          report_mismatch("hit", 32'(hit), 32'(want.hit));
        if (out_addr !== want.oaddr) report_mismatch("out_addr", out_addr, want.oaddr);
        if (out_data !== want.odata) report_mismatch("out_data", out_data, want.odata);
      end
    end
  end

  initial begin
    sb_result_t ok;
    sb_result_t refused;
    sbf_func_t  fn;
    int         n;
    int         k;
    int         w;
    int         mode;
    int         push_lim;
    int         pop_lim;
    int         flush_lim;

    for (k = 0; k < SBF_DEPTH; k++) begin
      sb_addr[k]  = '0;
      sb_data[k]  = '0;
      sb_valid[k] = 1'b0;
    end
    sb_head = 0;
    sb_tail = 0;
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFC;
    for (k = 2; k < 8; k++) addr_pool[k] = $urandom();
    ok      = mk_res(1'b0, 1'b0, '0, '0);
    refused = mk_res(1'b1, 1'b0, '0, '0);

    add_row(FN_POP,   32'h0000_0000, 32'h0000_0000, 1,  1, refused);
    add_row(FN_QUERY, 32'h0000_0000, 32'h0000_0000, 1,  1, ok);
    add_row(FN_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,  1, ok);
    add_row(FN_PUSH,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,  1, ok);
    add_row(FN_PUSH,  32'h0000_0000, 32'h0000_0000, 1,  1, ok);
    add_row(FN_PUSH,  32'hFFFF_FFFC, 32'h1234_5678, 1,  1, ok);
    add_row(FN_QUERY, 32'hFFFF_FFFE, 32'h0,
            1, 1, mk_res(1'b0, 1'b1, '0, 32'h1234_5678));
    add_row(FN_QUERY, 32'h0000_0003, 32'h0, 1, 1, mk_res(1'b0, 1'b1, '0, '0));
    add_row(FN_QUERY, 32'h0000_0004, 32'h0, 1, 1, ok);
    add_row(FN_POP,   32'h0,         32'h0,
            1, 1, mk_res(1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    add_row(FN_QUERY, 32'hFFFF_FFFF, 32'h0,
            1, 1, mk_res(1'b0, 1'b1, '0, 32'h1234_5678));
    add_row(FN_FLUSH, 32'h0,         32'h0,         1,  1, ok);
    add_row(FN_QUERY, 32'h0000_0000, 32'h0,         1,  1, ok);
    add_row(FN_POP,   32'h0,         32'h0,         1,  1, refused);
    add_row(FN_PUSH,  32'h0000_1000, 32'h0000_A000, 16, 0, ok);
    add_row(FN_PUSH,  32'hDEAD_BEEF, 32'hCAFE_F00D, 1,  1, refused);
    add_row(FN_QUERY, 32'h0000_1000, 32'h0,         1,  0, ok);
    add_row(FN_POP,   32'h0,         32'h0,         3,  0, ok);
    add_row(FN_PUSH,  32'h0000_2000, 32'h0000_B000, 3,  0, ok);
    add_row(FN_PUSH,  32'h0000_3000, 32'h0,         1,  1, refused);
    add_row(FN_QUERY, 32'h0000_200B, 32'h0,         1,  0, ok);
    add_row(FN_POP,   32'h0,         32'h0,         16, 0, ok);
    add_row(FN_POP,   32'h0,         32'h0,         1,  1, refused);
    add_row(FN_PUSH,  32'h5555_5555, 32'hAAAA_AAAA, 3,  0, ok);
    add_row(FN_FLUSH, 32'h0,         32'h0,         1,  1, ok);

    while (rst) @(posedge clk);

    foreach (dir_rows[r]) begin
      for (k = 0; k < dir_rows[r].count; k++)
        offer_item(dir_rows[r].fn, dir_rows[r].addr + 4 * k, dir_rows[r].value + k,
                   dir_rows[r].has_exp, dir_rows[r].exp);
    end

    mode = 2;
    for (n = 0; n < N_RANDOM; n++) begin
      if (n % 40 == 0) mode = $urandom_range(0, 2);
      if (n == 300) hold_request = 1'b1;
      steady = (n >= 700 && n < 950);
      case (mode)
        0: begin push_lim = 55; pop_lim = 70; flush_lim = 73; end
        1: begin push_lim = 15; pop_lim = 70; flush_lim = 73; end
        default: begin push_lim = 35; pop_lim = 65; flush_lim = 67; end
      endcase
      w = $urandom_range(0, 99);
      if (w < push_lim) fn = FN_PUSH;
      else if (w < pop_lim) fn = FN_POP;
      else if (w < flush_lim) fn = FN_FLUSH;
      else fn = FN_QUERY;
      offer_item(fn, pick_addr(), pick_value(), 0, ok);
    end
    steady = 1'b0;
    req_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("PASS store_buffer_with_forwarding");
    else
      $display("FAIL store_buffer_with_forwarding");
    $finish;
  end

endmodule
